// ----- rtl/adb_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// adb_pkg: shared types and constants of the announcement dedup batcher
// Status and flush-reason codes, register indexes, queue item and FSM types.
// ----------------------------------------------------------------------------
package adb_pkg;

	localparam int SLOT_BITS_DEF   = 2;
	localparam int TABLE_DEPTH_DEF = 4096;
	localparam int BATCH_LIMIT_DEF = 1024;

	localparam int KEY_W    = 64;
	localparam int HEIGHT_W = 32;
	localparam int TIME_W   = 40;
	localparam int CNT_W    = 10;
	localparam int CFG_W    = 16;
	localparam int CFG_IDX_W = 2;

	localparam int QUEUE_DEPTH = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_HASH_MOD       = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HASH_NUM       = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FLUSH_INTERVAL = 2'd2;

	localparam logic [15:0] FLUSH_INTERVAL_RST = 16'd60;

	typedef enum logic [2:0] {
		ST_ACCEPTED,
		ST_DUPLICATE,
		ST_RESERVED,
		ST_OTHER_SHARD,
		ST_TOO_OLD,
		ST_TABLE_FULL
	} status_t;

	typedef enum logic [1:0] {
		RS_NONE,
		RS_NEW_HEIGHT,
		RS_BATCH_FULL,
		RS_INTERVAL
	} reason_t;

	typedef struct packed {
		logic [KEY_W-1:0]    key;
		logic [HEIGHT_W-1:0] height;
		logic [TIME_W-1:0]   now;
		status_t             status;
	} q_item_t;

	typedef enum logic [1:0] {
		FS_IDLE,
		FS_DIV,
		FS_PUSH
	} front_state_t;

	typedef enum logic [1:0] {
		BS_IDLE,
		BS_DECIDE,
		BS_SCAN,
		BS_FIN
	} back_state_t;

endpackage
`default_nettype wire

// ----- rtl/adb_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// adb_front: key screening
// Rejects reserved keys and, by a bit-serial remainder, keys of other shards.
// ----------------------------------------------------------------------------
module adb_front (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          in_valid,
	output logic                         in_stall,
	input  wire  [adb_pkg::KEY_W-1:0]    dedup_key,
	input  wire  [adb_pkg::HEIGHT_W-1:0] parent_height,
	input  wire  [adb_pkg::TIME_W-1:0]   now_seconds,
	input  wire  [7:0]                   hash_mod,
	input  wire  [7:0]                   hash_num,
	input  wire                          q_full,
	output logic                         q_push,
	output adb_pkg::q_item_t             q_item
);
	import adb_pkg::*;

	front_state_t state_q, state_d;
	q_item_t      item_q;
	logic [KEY_W-1:0] key_sh_q;
	logic [7:0]   rem_q;
	logic [5:0]   cnt_q;
	logic [7:0]   modulo;
	logic [8:0]   rem_shift;
	logic [8:0]   rem_sub;
	logic [7:0]   rem_next;
	logic         accept;
	logic         reserved;

	assign modulo    = (hash_mod == 8'd0) ? 8'd1 : hash_mod;
	assign rem_shift = {rem_q, key_sh_q[KEY_W-1]};
	assign rem_sub   = rem_shift - {1'b0, modulo};
	assign rem_next  = (rem_shift >= {1'b0, modulo}) ? rem_sub[7:0] : rem_shift[7:0];
	assign accept    = in_valid && !in_stall;
	assign reserved  = (dedup_key == '0) || (dedup_key == '1);
	assign q_item    = item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_stall = 1'b1;
		q_push   = 1'b0;
		unique case (state_q)
			FS_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					state_d = reserved ? FS_PUSH : FS_DIV;
				end
			end
			FS_DIV: begin
				if (cnt_q == 6'd63) begin
					state_d = FS_PUSH;
				end
			end
			FS_PUSH: begin
				if (!q_full) begin
					q_push  = 1'b1;
					state_d = FS_IDLE;
				end
			end
			default: state_d = FS_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q.key    <= dedup_key;
			item_q.height <= parent_height;
			item_q.now    <= now_seconds;
			item_q.status <= reserved ? ST_RESERVED : ST_ACCEPTED;
			key_sh_q      <= dedup_key;
			rem_q         <= '0;
			cnt_q         <= '0;
		end else if (state_q == FS_DIV) begin
			rem_q    <= rem_next;
			key_sh_q <= {key_sh_q[KEY_W-2:0], 1'b0};
			cnt_q    <= cnt_q + 6'd1;
			if (cnt_q == 6'd63) begin
				item_q.status <= (rem_next == hash_num) ? ST_ACCEPTED : ST_OTHER_SHARD;
			end
		end
	end

endmodule
`default_nettype wire

// ----- rtl/adb_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// adb_queue: short item queue
// Decouples screening from the table scan.
// ----------------------------------------------------------------------------
module adb_queue (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               push,
	input  adb_pkg::q_item_t  push_item,
	output logic              full,
	input  wire               pop,
	output logic              head_valid,
	output adb_pkg::q_item_t  head
);
	import adb_pkg::*;

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	q_item_t         entry_q [QUEUE_DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign full       = (count_q == CW'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/adb_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// adb_back: slot batching and key table
// Per-slot flush decision, linear table scan, insert and result register.
// ----------------------------------------------------------------------------
module adb_back #(
	parameter int SLOT_BITS   = adb_pkg::SLOT_BITS_DEF,
	parameter int TABLE_DEPTH = adb_pkg::TABLE_DEPTH_DEF,
	parameter int BATCH_LIMIT = adb_pkg::BATCH_LIMIT_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire  [15:0]                  flush_interval,
	input  wire                          head_valid,
	input  adb_pkg::q_item_t             head,
	output logic                         pop,
	output logic                         out_valid,
	input  wire                          out_stall,
	output logic [2:0]                   status,
	output logic [1:0]                   slot,
	output logic [adb_pkg::CNT_W-1:0]    batch_index,
	output logic                         flushed,
	output logic [1:0]                   flush_reason,
	output logic [adb_pkg::HEIGHT_W-1:0] flushed_height,
	output logic [adb_pkg::CNT_W-1:0]    flushed_count
);
	import adb_pkg::*;

	localparam int NUM_SLOTS = 1 << SLOT_BITS;
	localparam int SI = (SLOT_BITS > 0) ? SLOT_BITS : 1;
	localparam int LW = $clog2(TABLE_DEPTH + 1);
	localparam int AW = $clog2(NUM_SLOTS * TABLE_DEPTH);
	localparam int BW = $clog2(BATCH_LIMIT);

	back_state_t state_q, state_d;

	logic [HEIGHT_W-1:0] slot_height_q [NUM_SLOTS];
	logic [BW-1:0]       batch_count_q [NUM_SLOTS];
	logic [TIME_W-1:0]   last_flush_q  [NUM_SLOTS];
	logic [LW-1:0]       table_len_q   [NUM_SLOTS];

	logic [KEY_W-1:0]    mem [NUM_SLOTS * TABLE_DEPTH];
	logic [KEY_W-1:0]    rdata_s1;
	logic                rv_s1;

	logic [KEY_W-1:0]    key_q;
	logic [HEIGHT_W-1:0] height_q;
	logic [TIME_W-1:0]   now_q;
	status_t             status_q;
	logic [SI-1:0]       sidx_q;
	logic [1:0]          slot_q;
	logic                flushed_q;
	reason_t             reason_q;
	logic [HEIGHT_W-1:0] fh_q;
	logic [BW-1:0]       fc_q;
	logic [LW-1:0]       scan_idx_q;
	logic                hit_q;

	logic                out_valid_q;
	logic [2:0]          status_q_out;
	logic [1:0]          slot_out_q;
	logic [CNT_W-1:0]    index_out_q;
	logic                flushed_out_q;
	logic [1:0]          reason_out_q;
	logic [HEIGHT_W-1:0] fh_out_q;
	logic [CNT_W-1:0]    fc_out_q;

	logic [HEIGHT_W-1:0] cur_h;
	logic [BW-1:0]       cur_cnt;
	logic [TIME_W-1:0]   cur_last;
	logic [LW-1:0]       cur_len;
	logic [AW-1:0]       base;
	logic                hit;
	logic                out_free;
	logic                batch_full;
	logic                late;
	logic                do_insert;
	status_t             fin_status;

	assign cur_h    = slot_height_q[sidx_q];
	assign cur_cnt  = batch_count_q[sidx_q];
	assign cur_last = last_flush_q[sidx_q];
	assign cur_len  = table_len_q[sidx_q];
	assign base     = AW'(sidx_q) * AW'(TABLE_DEPTH);
	assign hit      = rv_s1 && (rdata_s1 == key_q);
	assign out_free = !out_valid_q || !out_stall;

	assign batch_full = ({1'b0, cur_cnt} + (BW+1)'(1)) >= (BW+1)'(BATCH_LIMIT);
	assign late = ({1'b0, cur_last} + (TIME_W+1)'(flush_interval)) < {1'b0, now_q};

	always_comb begin
		fin_status = status_q;
		do_insert  = 1'b0;
		if (status_q == ST_ACCEPTED) begin
			if (hit_q) begin
				fin_status = ST_DUPLICATE;
			end else if (cur_len == LW'(TABLE_DEPTH)) begin
				fin_status = ST_TABLE_FULL;
			end else begin
				do_insert = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		pop     = 1'b0;
		unique case (state_q)
			BS_IDLE: begin
				if (head_valid) begin
					pop     = 1'b1;
					state_d = BS_DECIDE;
				end
			end
			BS_DECIDE: begin
				if (status_q != ST_ACCEPTED || height_q < cur_h) begin
					state_d = BS_FIN;
				end else begin
					state_d = BS_SCAN;
				end
			end
			BS_SCAN: begin
				if (hit || (scan_idx_q == cur_len && !rv_s1)) begin
					state_d = BS_FIN;
				end
			end
			BS_FIN: begin
				if (out_free) begin
					state_d = BS_IDLE;
				end
			end
			default: state_d = BS_IDLE;
		endcase
	end

	// per-slot state and control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SLOTS; i++) begin
				slot_height_q[i] <= '0;
				batch_count_q[i] <= '0;
				last_flush_q[i]  <= '0;
				table_len_q[i]   <= '0;
			end
			rv_s1       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == BS_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				BS_IDLE: rv_s1 <= 1'b0;
				BS_DECIDE: begin
					rv_s1 <= 1'b0;
					if (status_q == ST_ACCEPTED && height_q > cur_h) begin
						slot_height_q[sidx_q] <= height_q;
						batch_count_q[sidx_q] <= '0;
						table_len_q[sidx_q]   <= '0;
						last_flush_q[sidx_q]  <= now_q;
					end else if (status_q == ST_ACCEPTED && height_q == cur_h
						&& (batch_full || late)) begin
						batch_count_q[sidx_q] <= '0;
						last_flush_q[sidx_q]  <= now_q;
					end
				end
				BS_SCAN: rv_s1 <= (scan_idx_q < cur_len) && !hit;
				BS_FIN: begin
					rv_s1 <= 1'b0;
					if (out_free) begin
						if (do_insert) begin
							table_len_q[sidx_q]   <= cur_len + 1'b1;
							batch_count_q[sidx_q] <= cur_cnt + 1'b1;
						end
					end
				end
				default: rv_s1 <= 1'b0;
			endcase
		end
	end

	// item payload, scan and result data
	always_ff @(posedge clk) begin
		unique case (state_q)
			BS_IDLE: begin
				key_q     <= head.key;
				height_q  <= head.height;
				now_q     <= head.now;
				status_q  <= head.status;
				sidx_q    <= SI'(head.height) & SI'(NUM_SLOTS - 1);
				slot_q    <= head.height[1:0] & 2'(NUM_SLOTS - 1);
				flushed_q <= 1'b0;
				reason_q  <= RS_NONE;
				fh_q      <= '0;
				fc_q      <= '0;
			end
			BS_DECIDE: begin
				scan_idx_q <= '0;
				hit_q      <= 1'b0;
				if (status_q == ST_ACCEPTED) begin
					if (height_q < cur_h) begin
						status_q <= ST_TOO_OLD;
					end else if (height_q > cur_h) begin
						flushed_q <= 1'b1;
						reason_q  <= RS_NEW_HEIGHT;
						fh_q      <= cur_h;
						fc_q      <= cur_cnt;
					end else if ((batch_full || late) && cur_cnt != '0) begin
						flushed_q <= 1'b1;
						reason_q  <= batch_full ? RS_BATCH_FULL : RS_INTERVAL;
						fh_q      <= cur_h;
						fc_q      <= cur_cnt;
					end
				end
			end
			BS_SCAN: begin
				if (hit) begin
					hit_q <= 1'b1;
				end else if (scan_idx_q < cur_len) begin
					rdata_s1   <= mem[base + AW'(scan_idx_q)];
					scan_idx_q <= scan_idx_q + 1'b1;
				end
			end
			BS_FIN: begin
				if (out_free) begin
					status_q_out  <= fin_status;
					slot_out_q    <= slot_q;
					index_out_q   <= do_insert ? CNT_W'(cur_cnt) : '0;
					flushed_out_q <= flushed_q;
					reason_out_q  <= reason_q;
					fh_out_q      <= fh_q;
					fc_out_q      <= CNT_W'(fc_q);
					if (do_insert) begin
						mem[base + AW'(cur_len)] <= key_q;
					end
				end
			end
			default: hit_q <= 1'b0;
		endcase
	end

	assign out_valid      = out_valid_q;
	assign status         = status_q_out;
	assign slot           = slot_out_q;
	assign batch_index    = index_out_q;
	assign flushed        = flushed_out_q;
	assign flush_reason   = reason_out_q;
	assign flushed_height = fh_out_q;
	assign flushed_count  = fc_out_q;

endmodule
`default_nettype wire

// ----- rtl/announcement_dedup_batcher.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// announcement_dedup_batcher: dedup and height batching of announcements
// Screens keys by shard, batches them per height slot, rejects repeats.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall) takes one item: dedup_key, parent_height,
// now_seconds. Output channel (out_valid/out_stall) returns exactly one
// result item per input item, in order.
// Front: reserved-key check, then a bit-serial key remainder, one key bit a
// cycle, skipped for reserved keys, then a push into a 2-deep queue. Back:
// slot decision, linear scan of the slot's key table at one memory read a
// cycle, then a final state that inserts a new key and loads the result
// register once the output is free. The front screens the next item while
// the back scans the table for the current one.
// Reset clears the slot heights, counters, timers and table lengths at once;
// the key memory needs no clearing since only entries below a slot's table
// length are read. When out_stall is high the result register holds, the
// back stops in its final state and the queue then fills and stalls the
// front; the configuration registers are written through cfg_wen only.
module announcement_dedup_batcher #(
	parameter int SLOT_BITS   = adb_pkg::SLOT_BITS_DEF,
	parameter int TABLE_DEPTH = adb_pkg::TABLE_DEPTH_DEF,
	parameter int BATCH_LIMIT = adb_pkg::BATCH_LIMIT_DEF
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           cfg_wen,
	input  wire  [adb_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire  [adb_pkg::CFG_W-1:0]     cfg_data,
	input  wire                           in_valid,
	output logic                          in_stall,
	input  wire  [adb_pkg::KEY_W-1:0]     dedup_key,
	input  wire  [adb_pkg::HEIGHT_W-1:0]  parent_height,
	input  wire  [adb_pkg::TIME_W-1:0]    now_seconds,
	output logic                          out_valid,
	input  wire                           out_stall,
	output logic [2:0]                    status,
	output logic [1:0]                    slot,
	output logic [adb_pkg::CNT_W-1:0]     batch_index,
	output logic                          flushed,
	output logic [1:0]                    flush_reason,
	output logic [adb_pkg::HEIGHT_W-1:0]  flushed_height,
	output logic [adb_pkg::CNT_W-1:0]     flushed_count
);
	import adb_pkg::*;

	logic [7:0]  hash_mod_q;
	logic [7:0]  hash_num_q;
	logic [15:0] flush_interval_q;

	q_item_t push_item;
	q_item_t head;
	logic    q_push;
	logic    q_full;
	logic    q_pop;
	logic    head_valid;

	// configuration registers; unknown indexes are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_mod_q       <= '0;
			hash_num_q       <= '0;
			flush_interval_q <= FLUSH_INTERVAL_RST;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				CFG_HASH_MOD:       hash_mod_q       <= cfg_data[7:0];
				CFG_HASH_NUM:       hash_num_q       <= cfg_data[7:0];
				CFG_FLUSH_INTERVAL: flush_interval_q <= cfg_data;
				default:            hash_mod_q       <= hash_mod_q;
			endcase
		end
	end

	adb_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.dedup_key     (dedup_key),
		.parent_height (parent_height),
		.now_seconds   (now_seconds),
		.hash_mod      (hash_mod_q),
		.hash_num      (hash_num_q),
		.q_full        (q_full),
		.q_push        (q_push),
		.q_item        (push_item)
	);

	adb_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_item  (push_item),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (head_valid),
		.head       (head)
	);

	adb_back #(
		.SLOT_BITS   (SLOT_BITS),
		.TABLE_DEPTH (TABLE_DEPTH),
		.BATCH_LIMIT (BATCH_LIMIT)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.flush_interval (flush_interval_q),
		.head_valid     (head_valid),
		.head           (head),
		.pop            (q_pop),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.status         (status),
		.slot           (slot),
		.batch_index    (batch_index),
		.flushed        (flushed),
		.flush_reason   (flush_reason),
		.flushed_height (flushed_height),
		.flushed_count  (flushed_count)
	);

endmodule
`default_nettype wire
